// ----- hw/rtl/ptq_pkg.sv -----
// Shared types, codes and constants of the periodic timer queue.
`default_nettype none
package ptq_pkg;

    localparam int SLOTS_DEF       = 16;
    localparam int PERIOD_BITS_DEF = 32;
    localparam int TIME_W          = 48;
    localparam int MAX_EXPIRED     = 16;

    // Command codes
    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;
    localparam logic [1:0] CMD_VERDICT = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_REPLY   = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_IDLE    = 2'd2;

    // Reply status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_FREE_ID  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND   = 2'd2;
    localparam logic [1:0] ST_NOT_WAITING = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] timeout_ms;
        logic        one_shot;
        logic [4:0]  timer_id;
        logic        keep;
    } req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic [4:0] timer_id_res;
        logic       last;
    } res_t;

    // Operation broadcast to every cell of the queue
    typedef struct packed {
        logic ins;
        logic del;
        logic pop;
    } op_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ptq_ram.sv -----
// Generic single-port-write RAM with registered read.
`default_nettype none
module ptq_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/ptq_cell.sv -----
// One entry of the sorted timer queue: insert shifts right, delete shifts left.
`default_nettype none
module ptq_cell #(
    parameter int ID_W = 5
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ptq_pkg::op_t              op,
    input  wire logic [ptq_pkg::TIME_W-1:0] ins_exp,
    input  wire logic [ID_W-1:0]           ins_id,
    input  wire logic [ID_W-1:0]           del_id,
    input  wire logic                      prev_valid,
    input  wire logic [ptq_pkg::TIME_W-1:0] prev_exp,
    input  wire logic [ID_W-1:0]           prev_id,
    input  wire logic                      next_valid,
    input  wire logic [ptq_pkg::TIME_W-1:0] next_exp,
    input  wire logic [ID_W-1:0]           next_id,
    input  wire logic                      keep_in,
    output logic                           keep_out,
    input  wire logic                      shift_in,
    output logic                           shift_out,
    output logic                           valid,
    output logic      [ptq_pkg::TIME_W-1:0] exp_ms,
    output logic      [ID_W-1:0]           id
);
    import ptq_pkg::*;

    logic valid_reg;
    logic [TIME_W-1:0] exp_reg;
    logic [ID_W-1:0] id_reg;

    // Neighbour hand-off conditions
    always_comb
    begin
        keep_out  = valid_reg && (exp_reg <= ins_exp);
        shift_out = shift_in || (op.del && valid_reg && (id_reg == del_id));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (op.ins && !keep_out)
        begin
            if (keep_in)
            begin
                valid_reg <= 1'b1;
            end
            else
            begin
                valid_reg <= prev_valid;
            end
        end
        else if ((op.del || op.pop) && shift_out)
        begin
            valid_reg <= next_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.ins && !keep_out)
        begin
            exp_reg <= keep_in ? ins_exp : prev_exp;
            id_reg  <= keep_in ? ins_id : prev_id;
        end
        else if ((op.del || op.pop) && shift_out)
        begin
            exp_reg <= next_exp;
            id_reg  <= next_id;
        end
    end

    assign valid  = valid_reg;
    assign exp_ms = exp_reg;
    assign id     = id_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/periodic_timer_queue.sv -----
// Top level of the periodic timer queue: command sequencer, id pool and cell chain.
`default_nettype none
// Periodic timer queue. A command is taken when start is high and busy low;
// every result appears on res for one cycle with res_valid high and cannot be
// held off. Add and remove reply from the insert or remove state, or at once
// when the pool is exhausted or the id is out of range; a verdict replies at
// once on error and otherwise reads the period store (registered read) first,
// then may reinsert; a tick gives one idle notice when nothing is due,
// otherwise one notice per expired timer, up to 16, one notice per cycle as the
// head of the cell chain is popped. Inserts and removals shift the whole chain
// at once. There is no clearing pass after reset.
module periodic_timer_queue #(
    parameter int SLOTS       = ptq_pkg::SLOTS_DEF,
    parameter int PERIOD_BITS = ptq_pkg::PERIOD_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire ptq_pkg::req_t req,
    output logic               busy,
    output logic               res_valid,
    output ptq_pkg::res_t      res
);
    import ptq_pkg::*;

    localparam int ID_W  = $clog2(SLOTS + 1);
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CW    = (ID_W > 5) ? ID_W : 5;
    localparam int TW    = (PERIOD_BITS > 32) ? PERIOD_BITS : 32;
    localparam int CNT_W = $clog2(MAX_EXPIRED);
    localparam logic [PERIOD_BITS-1:0] PMAX = {PERIOD_BITS{1'b1}};

    typedef enum logic [2:0] {S_IDLE, S_INS, S_REM, S_TICK, S_VRD} state_t;

    state_t state_reg;
    logic [TIME_W-1:0] now_reg;
    logic [SLOTS-1:0] in_use_reg;
    logic [SLOTS-1:0] waiting_reg;
    logic [TIME_W-1:0] ins_exp_reg;
    logic [ID_W-1:0] ins_id_reg;
    logic [ID_W-1:0] tgt_id_reg;
    logic keep_reg;
    logic [CNT_W-1:0] cnt_reg;
    res_t res_reg;
    logic res_valid_reg;

    // Chain wiring
    logic cv [SLOTS];
    logic [TIME_W-1:0] cexp [SLOTS];
    logic [ID_W-1:0] cid [SLOTS];
    logic kc [SLOTS+1];
    logic sh [SLOTS+1];
    op_t op;

    // Period store
    logic ram_we;
    logic [PERIOD_BITS:0] ram_wdata;
    logic [PERIOD_BITS:0] ram_rdata;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;

    logic accept;
    logic [CW-1:0] id_wide;
    logic id_ok;
    logic [IDX_W-1:0] id_idx;
    logic free_found;
    logic [IDX_W-1:0] free_idx;
    logic [TW-1:0] tmo_wide;
    logic [PERIOD_BITS-1:0] period_sat;
    logic [TIME_W:0] add_sum;
    logic [TIME_W:0] vrd_sum;
    logic head_due;
    logic next_due;
    logic [IDX_W-1:0] head_idx;

    assign accept = start && (state_reg == S_IDLE);

    // Addressed id decode
    always_comb
    begin
        id_wide = CW'(req.timer_id);
        id_ok   = (id_wide >= CW'(1)) && (id_wide <= CW'(SLOTS));
        id_idx  = IDX_W'(id_wide - CW'(1));
    end

    // Lowest free id
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Period saturation and expiry sums
    always_comb
    begin
        tmo_wide   = TW'(req.timeout_ms);
        period_sat = (tmo_wide > TW'(PMAX)) ? PMAX : PERIOD_BITS'(tmo_wide);
        add_sum    = {1'b0, now_reg} + (TIME_W + 1)'(period_sat);
        vrd_sum    = {1'b0, now_reg} + (TIME_W + 1)'(ram_rdata[PERIOD_BITS-1:0]);
    end

    // Head of queue checks for tick
    always_comb
    begin
        head_due = cv[0] && (cexp[0] <= now_reg);
        next_due = cv[1] && (cexp[1] <= now_reg);
        head_idx = IDX_W'(cid[0] - ID_W'(1));
    end

    always_comb
    begin
        op.ins = (state_reg == S_INS);
        op.del = (state_reg == S_REM);
        op.pop = (state_reg == S_TICK) && head_due;
    end

    assign ram_we    = accept && (req.cmd == CMD_ADD) && free_found;
    assign ram_waddr = free_idx;
    assign ram_wdata = {req.one_shot, period_sat};
    assign ram_raddr = id_idx;

    ptq_ram #(
        .W (PERIOD_BITS + 1),
        .D (SLOTS)
    ) u_period (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Cell chain
    assign kc[0] = 1'b1;
    assign sh[0] = op.pop;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        logic pv;
        logic [TIME_W-1:0] pe;
        logic [ID_W-1:0] pi;
        logic nv;
        logic [TIME_W-1:0] ne;
        logic [ID_W-1:0] ni;

        if (g == 0)
        begin : g_first
            assign pv = 1'b0;
            assign pe = '0;
            assign pi = '0;
        end
        else
        begin : g_mid
            assign pv = cv[g-1];
            assign pe = cexp[g-1];
            assign pi = cid[g-1];
        end

        if (g == SLOTS - 1)
        begin : g_last
            assign nv = 1'b0;
            assign ne = '0;
            assign ni = '0;
        end
        else
        begin : g_inner
            assign nv = cv[g+1];
            assign ne = cexp[g+1];
            assign ni = cid[g+1];
        end

        ptq_cell #(
            .ID_W (ID_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .ins_exp    (ins_exp_reg),
            .ins_id     (ins_id_reg),
            .del_id     (tgt_id_reg),
            .prev_valid (pv),
            .prev_exp   (pe),
            .prev_id    (pi),
            .next_valid (nv),
            .next_exp   (ne),
            .next_id    (ni),
            .keep_in    (kc[g]),
            .keep_out   (kc[g+1]),
            .shift_in   (sh[g]),
            .shift_out  (sh[g+1]),
            .valid      (cv[g]),
            .exp_ms     (cexp[g]),
            .id         (cid[g])
        );
    end

    // Command sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            now_reg       <= '0;
            in_use_reg    <= '0;
            waiting_reg   <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            ins_exp_reg   <= '0;
            ins_id_reg    <= '0;
            tgt_id_reg    <= '0;
            keep_reg      <= 1'b0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        keep_reg   <= req.keep;
                        tgt_id_reg <= ID_W'(id_wide);
                        case (req.cmd)
                            CMD_ADD:
                            begin
                                if (free_found)
                                begin
                                    in_use_reg[free_idx]  <= 1'b1;
                                    waiting_reg[free_idx] <= 1'b0;
                                    ins_id_reg  <= ID_W'(free_idx) + ID_W'(1);
                                    ins_exp_reg <= add_sum[TIME_W] ? {TIME_W{1'b1}}
                                                                   : add_sum[TIME_W-1:0];
                                    state_reg   <= S_INS;
                                end
                                else
                                begin
                                    res_valid_reg <= 1'b1;
                                    res_reg <= '{KIND_REPLY, ST_NO_FREE_ID, 5'd0, 1'b1};
                                end
                            end
                            CMD_REMOVE:
                            begin
                                if (!id_ok)
                                begin
                                    res_valid_reg <= 1'b1;
                                    res_reg <= '{KIND_REPLY, ST_NOT_FOUND, 5'd0, 1'b1};
                                end
                                else
                                begin
                                    state_reg <= S_REM;
                                end
                            end
                            CMD_TICK:
                            begin
                                now_reg   <= now_reg + TIME_W'(1);
                                cnt_reg   <= '0;
                                state_reg <= S_TICK;
                            end
                            default:
                            begin
                                if (!id_ok || !in_use_reg[id_idx])
                                begin
                                    res_valid_reg <= 1'b1;
                                    res_reg <= '{KIND_REPLY, ST_NOT_FOUND, 5'd0, 1'b1};
                                end
                                else if (!waiting_reg[id_idx])
                                begin
                                    res_valid_reg <= 1'b1;
                                    res_reg <= '{KIND_REPLY, ST_NOT_WAITING, 5'd0, 1'b1};
                                end
                                else
                                begin
                                    waiting_reg[id_idx] <= 1'b0;
                                    state_reg <= S_VRD;
                                end
                            end
                        endcase
                    end
                end
                S_INS:
                begin
                    res_valid_reg <= 1'b1;
                    res_reg   <= '{KIND_REPLY, ST_OK, 5'(ins_id_reg), 1'b1};
                    state_reg <= S_IDLE;
                end
                S_REM:
                begin
                    res_valid_reg <= 1'b1;
                    if (sh[SLOTS])
                    begin
                        in_use_reg[IDX_W'(tgt_id_reg - ID_W'(1))] <= 1'b0;
                        res_reg <= '{KIND_REPLY, ST_OK, 5'(tgt_id_reg), 1'b1};
                    end
                    else
                    begin
                        res_reg <= '{KIND_REPLY, ST_NOT_FOUND, 5'd0, 1'b1};
                    end
                    state_reg <= S_IDLE;
                end
                S_TICK:
                begin
                    res_valid_reg <= 1'b1;
                    if (head_due)
                    begin
                        waiting_reg[head_idx] <= 1'b1;
                        res_reg <= '{KIND_EXPIRED, ST_OK, 5'(cid[0]),
                                     (!next_due || (cnt_reg == CNT_W'(MAX_EXPIRED - 1)))};
                        cnt_reg <= cnt_reg + CNT_W'(1);
                        if (!next_due || (cnt_reg == CNT_W'(MAX_EXPIRED - 1)))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        res_reg   <= '{KIND_IDLE, ST_OK, 5'd0, 1'b1};
                        state_reg <= S_IDLE;
                    end
                end
                S_VRD:
                begin
                    if (keep_reg && !ram_rdata[PERIOD_BITS])
                    begin
                        ins_id_reg  <= tgt_id_reg;
                        ins_exp_reg <= vrd_sum[TIME_W] ? {TIME_W{1'b1}}
                                                       : vrd_sum[TIME_W-1:0];
                        state_reg   <= S_INS;
                    end
                    else
                    begin
                        in_use_reg[IDX_W'(tgt_id_reg - ID_W'(1))] <= 1'b0;
                        res_valid_reg <= 1'b1;
                        res_reg   <= '{KIND_REPLY, ST_OK, 5'(tgt_id_reg), 1'b1};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
endmodule
`default_nettype wire
